// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked at every clock edge out of reset
`define MTPE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// antecedent holds, consequent must follow on the next edge
`define MTPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/mtpe_pkg.sv -----
// ----------------------------------------------------------------------------
// mtpe_pkg
// types, codes and constants of the mission transfer protocol engine
// ----------------------------------------------------------------------------
package mtpe_pkg;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [3:0]  RETRY_RESET   = 4'd3;
    localparam logic        GOTO_RESET    = 1'b1;

    typedef enum logic [3:0] {
        CMD_TICK    = 4'd0,
        CMD_ITEM    = 4'd1,
        CMD_REQUEST = 4'd2,
        CMD_CURRENT = 4'd3,
        CMD_COUNT   = 4'd4,
        CMD_ACK     = 4'd5,
        CMD_PULL    = 4'd6,
        CMD_PUSH    = 4'd7,
        CMD_CLEAR   = 4'd8,
        CMD_SETCUR  = 4'd9,
        CMD_GOTO    = 4'd10
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_RXLIST = 3'd1,
        PH_RXITEM = 3'd2,
        PH_TXLIST = 3'd3,
        PH_TXITEM = 3'd4,
        PH_CLEAR  = 3'd5,
        PH_SETCUR = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        SEND_NONE      = 3'd0,
        SEND_REQ_LIST  = 3'd1,
        SEND_REQUEST   = 3'd2,
        SEND_COUNT     = 3'd3,
        SEND_ITEM      = 3'd4,
        SEND_CLEAR_ALL = 3'd5,
        SEND_SET_CUR   = 3'd6,
        SEND_ACK_OK    = 3'd7
    } t_send_kind;

    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_LIST_RX    = 4'd1,
        EV_PUSH_DONE  = 4'd2,
        EV_PUSH_FAIL  = 4'd3,
        EV_CLEARED    = 4'd4,
        EV_CLEAR_FAIL = 4'd5,
        EV_ACTIVE     = 4'd6,
        EV_TIMEOUT    = 4'd7,
        EV_BUSY       = 4'd8,
        EV_MISMATCH   = 4'd9,
        EV_OUT_RANGE  = 4'd10,
        EV_IGNORED    = 4'd11
    } t_event;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_RETRY   = 2'd1;
    localparam logic [1:0] CFG_GOTO    = 2'd2;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [3:0]  retry_limit;
        logic        goto_supported;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [15:0] seq;
        logic [15:0] count;
        logic [7:0]  ack_type;
    } t_item;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] item_total;
        logic [15:0] next_index;
        logic [15:0] active_index;
        logic [15:0] wanted_active;
        logic [3:0]  retries_left;
        logic [15:0] timer_left;
    } t_state;

    typedef struct packed {
        t_send_kind  send_kind;
        logic [15:0] send_value;
        logic        store_item;
        logic [15:0] store_index;
        t_event      event_res;
        logic [15:0] event_value;
    } t_result;

endpackage

// ----- rtl/mtpe_step.sv -----
// ----------------------------------------------------------------------------
// mtpe_step
// next state and result of the protocol engine for one transaction
// ----------------------------------------------------------------------------
module mtpe_step import mtpe_pkg::*; (
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_res
);

    logic [16:0] next_plus1;
    logic [16:0] total_ext;
    logic [16:0] seq_ext;
    logic [15:0] reload;
    logic [15:0] timer_dec;
    logic        last_item;

    assign next_plus1 = {1'b0, i_state.next_index} + 17'd1;
    assign total_ext  = {1'b0, i_state.item_total};
    assign seq_ext    = {1'b0, i_item.seq};
    assign reload     = (i_cfg.timeout_ticks == 16'd0) ? 16'd1 : i_cfg.timeout_ticks;
    assign timer_dec  = i_state.timer_left - 16'd1;
    assign last_item  = (i_state.item_total == 16'd0) || (next_plus1 == total_ext);

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        o_res.send_kind = SEND_NONE;
        o_res.event_res = EV_NONE;

        if ((i_item.cmd inside {[CMD_PULL:CMD_GOTO]}) && (i_state.phase != PH_IDLE)) begin
            o_res.event_res = EV_BUSY;
        end else begin
            case (i_item.cmd)
                CMD_TICK: begin
                    if (i_state.timer_left != 16'd0) begin
                        o_state.timer_left = timer_dec;
                        if (timer_dec == 16'd0) begin
                            if (i_state.retries_left != 4'd0) begin
                                o_state.retries_left = i_state.retries_left - 4'd1;
                                o_state.timer_left   = reload;
                                // resend whatever the phase last put on the link
                                case (i_state.phase)
                                    PH_RXLIST: o_res.send_kind = SEND_REQ_LIST;
                                    PH_RXITEM: begin
                                        o_res.send_kind  = SEND_REQUEST;
                                        o_res.send_value = i_state.next_index;
                                    end
                                    PH_TXLIST: begin
                                        o_res.send_kind  = SEND_COUNT;
                                        o_res.send_value = i_state.item_total;
                                    end
                                    PH_TXITEM: begin
                                        if (i_state.next_index < i_state.item_total) begin
                                            o_res.send_kind  = SEND_ITEM;
                                            o_res.send_value = i_state.next_index;
                                        end
                                    end
                                    PH_CLEAR: o_res.send_kind = SEND_CLEAR_ALL;
                                    PH_SETCUR: begin
                                        o_res.send_kind  = SEND_SET_CUR;
                                        o_res.send_value = i_state.wanted_active;
                                    end
                                    default: o_res.send_kind = SEND_NONE;
                                endcase
                            end else begin
                                o_state.phase      = PH_IDLE;
                                o_state.timer_left = 16'd0;
                                o_res.event_res    = EV_TIMEOUT;
                            end
                        end
                    end
                end
                CMD_ITEM: begin
                    if (i_state.phase != PH_RXITEM) begin
                        o_res.event_res = EV_IGNORED;
                    end else if (i_item.seq != i_state.next_index) begin
                        o_res.event_res = EV_MISMATCH;
                    end else begin
                        o_res.store_item   = 1'b1;
                        o_res.store_index  = i_state.next_index;
                        o_state.next_index = next_plus1[15:0];
                        if (next_plus1 < total_ext) begin
                            o_state.retries_left = i_cfg.retry_limit;
                            o_state.timer_left   = reload;
                            o_res.send_kind      = SEND_REQUEST;
                            o_res.send_value     = next_plus1[15:0];
                        end else begin
                            o_state.phase      = PH_IDLE;
                            o_state.timer_left = 16'd0;
                            o_res.send_kind    = SEND_ACK_OK;
                            o_res.event_res    = EV_LIST_RX;
                        end
                    end
                end
                CMD_REQUEST: begin
                    if (!((i_state.phase == PH_TXLIST && i_item.seq == 16'd0) ||
                          i_state.phase == PH_TXITEM)) begin
                        o_res.event_res = EV_IGNORED;
                    end else if (seq_ext != {1'b0, i_state.next_index} &&
                                 seq_ext != next_plus1) begin
                        o_res.event_res = EV_MISMATCH;
                    end else begin
                        o_state.retries_left = i_cfg.retry_limit;
                        o_state.timer_left   = reload;
                        if (i_item.seq < i_state.item_total) begin
                            o_state.phase      = PH_TXITEM;
                            o_state.next_index = i_item.seq;
                            o_res.send_kind    = SEND_ITEM;
                            o_res.send_value   = i_item.seq;
                        end else begin
                            o_res.event_res   = EV_OUT_RANGE;
                            o_res.event_value = i_item.seq;
                        end
                    end
                end
                CMD_CURRENT: begin
                    if (i_state.phase == PH_SETCUR) begin
                        o_state.phase        = PH_IDLE;
                        o_state.timer_left   = 16'd0;
                        o_state.active_index = i_item.seq;
                        o_res.event_res      = EV_ACTIVE;
                        o_res.event_value    = i_item.seq;
                    end else if (i_state.phase == PH_IDLE &&
                                 i_state.active_index != i_item.seq) begin
                        o_state.active_index = i_item.seq;
                        o_res.event_res      = EV_ACTIVE;
                        o_res.event_value    = i_item.seq;
                    end
                end
                CMD_COUNT: begin
                    if (i_state.phase != PH_RXLIST) begin
                        o_res.event_res = EV_IGNORED;
                    end else begin
                        o_state.item_total = i_item.count;
                        o_state.next_index = 16'd0;
                        if (i_item.count != 16'd0) begin
                            o_state.phase        = PH_RXITEM;
                            o_state.retries_left = i_cfg.retry_limit;
                            o_state.timer_left   = reload;
                            o_res.send_kind      = SEND_REQUEST;
                        end else begin
                            o_state.phase      = PH_IDLE;
                            o_state.timer_left = 16'd0;
                            o_res.send_kind    = SEND_ACK_OK;
                            o_res.event_res    = EV_LIST_RX;
                        end
                    end
                end
                CMD_ACK: begin
                    if (i_state.phase == PH_TXLIST || i_state.phase == PH_TXITEM) begin
                        o_state.phase      = PH_IDLE;
                        o_state.timer_left = 16'd0;
                        if (last_item && i_item.ack_type == 8'd0) begin
                            o_res.event_res = EV_PUSH_DONE;
                        end else begin
                            o_res.event_res   = EV_PUSH_FAIL;
                            o_res.event_value = {8'd0, i_item.ack_type};
                        end
                    end else if (i_state.phase == PH_CLEAR) begin
                        o_state.phase      = PH_IDLE;
                        o_state.timer_left = 16'd0;
                        if (i_item.ack_type != 8'd0) begin
                            o_res.event_res   = EV_CLEAR_FAIL;
                            o_res.event_value = {8'd0, i_item.ack_type};
                        end else begin
                            o_res.event_res = EV_CLEARED;
                        end
                    end else begin
                        o_res.event_res = EV_IGNORED;
                    end
                end
                CMD_PULL: begin
                    o_state.phase        = PH_RXLIST;
                    o_state.item_total   = 16'd0;
                    o_state.retries_left = i_cfg.retry_limit;
                    o_state.timer_left   = reload;
                    o_res.send_kind      = SEND_REQ_LIST;
                end
                CMD_PUSH: begin
                    o_state.phase        = PH_TXLIST;
                    o_state.item_total   = i_item.count;
                    o_state.next_index   = 16'd0;
                    o_state.retries_left = i_cfg.retry_limit;
                    o_state.timer_left   = reload;
                    o_res.send_kind      = SEND_COUNT;
                    o_res.send_value     = i_item.count;
                end
                CMD_CLEAR: begin
                    o_state.phase        = PH_CLEAR;
                    o_state.retries_left = i_cfg.retry_limit;
                    o_state.timer_left   = reload;
                    o_res.send_kind      = SEND_CLEAR_ALL;
                end
                CMD_SETCUR: begin
                    o_state.phase         = PH_SETCUR;
                    o_state.wanted_active = i_item.seq;
                    o_state.retries_left  = i_cfg.retry_limit;
                    o_state.timer_left    = reload;
                    o_res.send_kind       = SEND_SET_CUR;
                    o_res.send_value      = i_item.seq;
                end
                CMD_GOTO: begin
                    if (!i_cfg.goto_supported) begin
                        o_res.event_res = EV_IGNORED;
                    end else begin
                        // a goto is a one-item push
                        o_state.phase        = PH_TXITEM;
                        o_state.item_total   = 16'd1;
                        o_state.next_index   = 16'd0;
                        o_state.retries_left = i_cfg.retry_limit;
                        o_state.timer_left   = reload;
                        o_res.send_kind      = SEND_ITEM;
                    end
                end
                default: o_res.event_res = EV_IGNORED;
            endcase
        end
    end

endmodule

// ----- rtl/mission_transfer_protocol_engine.sv -----
// ----------------------------------------------------------------------------
// mission_transfer_protocol_engine
// client side of a mission list transfer: pull, push, clear, set current, goto
// ----------------------------------------------------------------------------
// Every accepted transaction (a local command, a received link message or a
// timer tick) gives exactly one result transaction: the message to send, the
// store slot of a received item and an event. One transaction is accepted per
// clock cycle unless back-pressure stalls the input side; it passes through the
// input register and then the result register, and the protocol state is
// updated in that same single pass. Back-pressure on the result side stalls
// the input side only once both registers are full. Configuration is written
// through its own channel, which is always ready.
`include "assert_macros.svh"

module mission_transfer_protocol_engine import mtpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // seq [15:0], count [31:16], ack_type [39:32]
    input  logic [3:0]  s_axis_tuser,   // cmd [3:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // send_value [15:0], store_index [31:16],
                                        // event_value [47:32]
    output logic [7:0]  m_axis_tuser    // send_kind [2:0], store_item [3], event_res [7:4]
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_in;
    logic    r_in_valid;
    t_result n_res;
    t_result r_res;
    logic    r_out_valid;
    logic    advance;

    assign o_cfg_ready   = 1'b1;
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks  <= TIMEOUT_RESET;
            r_cfg.retry_limit    <= RETRY_RESET;
            r_cfg.goto_supported <= GOTO_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_cfg.timeout_ticks  <= i_cfg_data;
                CFG_RETRY:   r_cfg.retry_limit    <= i_cfg_data[3:0];
                CFG_GOTO:    r_cfg.goto_supported <= i_cfg_data[0];
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.cmd      <= s_axis_tuser;
            r_in.seq      <= s_axis_tdata[15:0];
            r_in.count    <= s_axis_tdata[31:16];
            r_in.ack_type <= s_axis_tdata[39:32];
        end
    end

    mtpe_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= PH_IDLE;
            r_state.item_total    <= 16'd0;
            r_state.next_index    <= 16'd0;
            r_state.active_index  <= 16'd0;
            r_state.wanted_active <= 16'd0;
            r_state.retries_left  <= 4'd0;
            r_state.timer_left    <= 16'd0;
            r_out_valid           <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_res.event_value, r_res.store_index, r_res.send_value};
    assign m_axis_tuser  = {r_res.event_res, r_res.store_item, r_res.send_kind};

    // the progress timer runs exactly while a transfer is open
    `MTPE_ASSERT(a_timer_tracks_phase,
        (r_state.phase == PH_IDLE) == (r_state.timer_left == 16'd0),
        "timer state disagrees with phase")

    // a stored item always comes with a follow-up request or list completion
    `MTPE_ASSERT(a_store_event,
        !(r_out_valid && r_res.store_item) ||
        (r_res.event_res == EV_NONE && r_res.send_kind == SEND_REQUEST) ||
        (r_res.event_res == EV_LIST_RX && r_res.send_kind == SEND_ACK_OK),
        "stored item without matching request or completion")

    // a held input transaction is never dropped while the result side stalls
    `MTPE_ASSERT_NEXT(a_input_kept, r_in_valid && !advance, r_in_valid,
        "input register lost a transaction under back-pressure")

endmodule
